// ===== rtl/core/indexed_shift_list_core_macros.svh =====
// Assertion macros for the indexed shift list core.
// Used by the port-level checker; needs clk_i and rst_ni in scope.
`ifndef INDEXED_SHIFT_LIST_CORE_MACROS_SVH
`define INDEXED_SHIFT_LIST_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define ISL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("isl check failed");

// Next-cycle implication, sampled on clk_i, off during reset
`define ISL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("isl check failed");

`endif

// ===== rtl/core/isl_pkg.sv =====
// Shared types and constants for the indexed shift list core.
// No dependencies; used by every module of the block.
package isl_pkg;

  localparam int Capacity  = 64;
  localparam int WordBits  = 32;
  localparam int IdxBits   = $clog2(Capacity);
  localparam int CountBits = $clog2(Capacity + 1);

  // Command opcodes
  typedef enum logic [2:0] {
    OpInsert = 3'd0,
    OpDelete = 3'd1,
    OpRead   = 3'd2,
    OpWrite  = 3'd3,
    OpClear  = 3'd4
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StRange = 2'd2
  } status_e;

  // Per-cycle action broadcast along the cell row
  typedef enum logic [1:0] {
    CellHold   = 2'd0,
    CellInsert = 2'd1,
    CellDelete = 2'd2,
    CellWrite  = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e              op;
    logic [IdxBits-1:0]    pos;
    logic [WordBits-1:0]   word;
  } cell_ctl_t;

  // Command and result payloads
  typedef struct packed {
    logic [2:0]          operation;
    logic [5:0]          position;
    logic [WordBits-1:0] word_in;
  } cmd_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [WordBits-1:0]  word_out;
    logic [CountBits-1:0] entry_count;
  } result_t;

endpackage

// ===== rtl/core/isl_cell.sv =====
// One storage cell of the shift list row.
// Depends on isl_pkg; takes its neighbors' words for shifting.
module isl_cell (
  input  logic                           clk_i,
  input  logic [isl_pkg::IdxBits-1:0]    index_i,
  input  isl_pkg::cell_ctl_t             ctl_i,
  input  logic [isl_pkg::WordBits-1:0]   left_i,
  input  logic [isl_pkg::WordBits-1:0]   right_i,
  input  logic [isl_pkg::IdxBits-1:0]    rd_pos_i,
  output logic [isl_pkg::WordBits-1:0]   word_o,
  output logic [isl_pkg::WordBits-1:0]   rd_word_o
);

  logic [isl_pkg::WordBits-1:0] word_q;
  logic [isl_pkg::WordBits-1:0] word_d;

  // Next word: load, shift from a neighbor, or hold
  always_comb begin
    word_d = word_q;
    case (ctl_i.op)
      isl_pkg::CellInsert: begin
        if (index_i == ctl_i.pos) begin
          word_d = ctl_i.word;
        end else if (index_i > ctl_i.pos) begin
          word_d = left_i;
        end
      end
      isl_pkg::CellDelete: begin
        if (index_i >= ctl_i.pos) begin
          word_d = right_i;
        end
      end
      isl_pkg::CellWrite: begin
        if (index_i == ctl_i.pos) begin
          word_d = ctl_i.word;
        end
      end
      default: word_d = word_q;
    endcase
  end

  // Payload storage, no reset
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o    = word_q;
  // Gated read tap, ORed across the row
  assign rd_word_o = (index_i == rd_pos_i) ? word_q : '0;

endmodule

// ===== rtl/core/isl_ctrl.sv =====
// Command decode, entry count and result register of the shift list.
// Depends on isl_pkg; drives the cell row control broadcast.
module isl_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  isl_pkg::cmd_t                 cmd_i,
  input  logic [isl_pkg::WordBits-1:0]  rd_word_i,
  output isl_pkg::cell_ctl_t            ctl_o,
  output logic                          done_o,
  output isl_pkg::result_t              result_o
);

  logic [isl_pkg::CountBits-1:0] count_q, count_d;
  logic [isl_pkg::CountBits-1:0] count_m1;
  logic [isl_pkg::CountBits-1:0] pos_ext;
  logic                          done_q;
  isl_pkg::result_t              result_q, result_d;

  assign count_m1 = count_q - 1'b1;
  assign pos_ext  = isl_pkg::CountBits'(cmd_i.position);

  // Decode one command against the current count
  always_comb begin
    count_d              = count_q;
    ctl_o.op             = isl_pkg::CellHold;
    ctl_o.pos            = cmd_i.position;
    ctl_o.word           = cmd_i.word_in;
    result_d.status      = isl_pkg::StOk;
    result_d.word_out    = '0;
    if (accept_i) begin
      case (cmd_i.operation)
        isl_pkg::OpInsert: begin
          if (count_q >= isl_pkg::CountBits'(isl_pkg::Capacity)) begin
            result_d.status = isl_pkg::StFull;
          end else begin
            // at or past the end appends
            if (pos_ext > count_q) begin
              ctl_o.pos = count_q[isl_pkg::IdxBits-1:0];
            end
            ctl_o.op = isl_pkg::CellInsert;
            count_d  = count_q + 1'b1;
          end
        end
        isl_pkg::OpDelete: begin
          if (pos_ext >= count_q) begin
            result_d.status = isl_pkg::StRange;
          end else begin
            result_d.word_out = rd_word_i;
            ctl_o.op          = isl_pkg::CellDelete;
            count_d           = count_m1;
          end
        end
        isl_pkg::OpRead: begin
          if (pos_ext >= count_q) begin
            result_d.status = isl_pkg::StRange;
          end else begin
            result_d.word_out = rd_word_i;
          end
        end
        isl_pkg::OpWrite: begin
          if (count_q == '0) begin
            result_d.status = isl_pkg::StRange;
          end else begin
            // past the end overwrites the last entry
            if (pos_ext >= count_q) begin
              ctl_o.pos = count_m1[isl_pkg::IdxBits-1:0];
            end
            ctl_o.op = isl_pkg::CellWrite;
          end
        end
        isl_pkg::OpClear: begin
          count_d = '0;
        end
        default: count_d = count_q;
      endcase
    end
    result_d.entry_count = count_d;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept_i;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ===== rtl/core/indexed_shift_list_core.sv =====
// Indexed shift list core: a fixed-capacity ordered list of words.
// Command channel: drive cmd_i with start high; the command transfers at the
//   clock edge where start is high and busy is low. busy stays low, so a
//   command can be issued every cycle.
// Commands: insert at an index (later entries move up, past the end
//   appends), delete (later entries move down, removed word returned),
//   read, write (past the end hits the last entry) and clear.
// Result channel: one result per command, shown on result_o for exactly one
//   cycle with done_o high, in the cycle after the command transfers.
// Throughput 1 command per cycle: every entry sits in its own cell of a row
//   that shifts all entries in the same clock.
// The receiver cannot stall; each result must be taken in its cycle.
// Reset empties the list (count zero); cell contents are not cleared and
//   are never returned before being written.
// Depends on isl_pkg, isl_cell and isl_ctrl.
module indexed_shift_list_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  isl_pkg::cmd_t     cmd_i,
  output logic              done_o,
  output isl_pkg::result_t  result_o
);

  logic                         accept;
  isl_pkg::cell_ctl_t           cell_ctl;
  logic [isl_pkg::WordBits-1:0] cell_word [isl_pkg::Capacity];
  logic [isl_pkg::WordBits-1:0] cell_rd   [isl_pkg::Capacity];
  logic [isl_pkg::WordBits-1:0] rd_word;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Control and result register
  isl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .cmd_i     (cmd_i),
    .rd_word_i (rd_word),
    .ctl_o     (cell_ctl),
    .done_o    (done_o),
    .result_o  (result_o)
  );

  // Row of cells, each wired to its neighbors
  for (genvar i = 0; i < isl_pkg::Capacity; i++) begin : g_cell
    logic [isl_pkg::WordBits-1:0] left_w;
    logic [isl_pkg::WordBits-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[i-1];
    end
    if (i == isl_pkg::Capacity - 1) begin : g_last
      assign right_w = cell_word[i];
    end else begin : g_mid_r
      assign right_w = cell_word[i+1];
    end
    isl_cell u_cell (
      .clk_i     (clk_i),
      .index_i   (isl_pkg::IdxBits'(i)),
      .ctl_i     (cell_ctl),
      .left_i    (left_w),
      .right_i   (right_w),
      .rd_pos_i  (cmd_i.position[isl_pkg::IdxBits-1:0]),
      .word_o    (cell_word[i]),
      .rd_word_o (cell_rd[i])
    );
  end

  // Combine the gated read taps
  always_comb begin
    rd_word = '0;
    for (int k = 0; k < isl_pkg::Capacity; k++) begin
      rd_word = rd_word | cell_rd[k];
    end
  end

endmodule

// ===== rtl/core/isl_checker.sv =====
// Port-level checker for the indexed shift list core, bound to the top.
// Depends on isl_pkg and indexed_shift_list_core_macros.svh.
`include "indexed_shift_list_core_macros.svh"

module isl_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input isl_pkg::result_t  result_o
);

  // One result in the cycle after each transfer, none otherwise
  `ISL_ASSERT_NEXT(a_done_follows, start && !busy, done_o)
  `ISL_ASSERT_NEXT(a_no_spurious_done, !(start && !busy), !done_o)
  // Count never exceeds capacity
  `ISL_ASSERT_NOW(a_count_range, done_o,
                  result_o.entry_count <= isl_pkg::CountBits'(isl_pkg::Capacity))
  // Full only reported at capacity
  `ISL_ASSERT_NOW(a_full_at_cap, done_o && result_o.status == isl_pkg::StFull,
                  result_o.entry_count == isl_pkg::CountBits'(isl_pkg::Capacity))
  // Failed commands return no word
  `ISL_ASSERT_NOW(a_err_no_word, done_o && result_o.status != isl_pkg::StOk,
                  result_o.word_out == '0)

endmodule

bind indexed_shift_list_core isl_checker u_isl_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for indexed_shift_list_core: list operations in, one result out.
// Needs isl_pkg and the core RTL. It predicts every result with its own list model and
// compares it field by field.
`timescale 1ns / 1ps

module testbench;

  // Operation codes beyond clear; the core must ignore them
  localparam logic [2:0] FirstSpareOp = 3'd5;
  localparam logic [2:0] LastSpareOp  = 3'd7;
  localparam int         RandomCmds   = 1850;

  typedef struct {
    isl_pkg::cmd_t cmd;
    int            gap_pct;  // chance of an idle cycle before this command
  } pending_cmd_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start;
  logic             busy;
  isl_pkg::cmd_t    cmd_i;
  logic             done_o;
  isl_pkg::result_t result_o;

  pending_cmd_t     pending_q[$];
  isl_pkg::result_t expected_q[$];
  int               issue_count    = 0;
  int               xfer_count     = 0;
  int               total_cmds     = 0;
  int               mismatch_count = 0;
  int               full_refusals  = 0;
  int               range_errors   = 0;
  int               peak_len       = 0;

  // List model: words in positions 0..list_len-1
  logic [isl_pkg::WordBits-1:0] list_words [isl_pkg::Capacity];
  int                           list_len = 0;

  indexed_shift_list_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_i    (cmd_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always #5 clk_i = ~clk_i;

  // Apply one command to the list model and return the result it should give
  function automatic isl_pkg::result_t apply_list_cmd(isl_pkg::cmd_t c);
    isl_pkg::result_t r;
    int               p;
    r = '0;
    r.status = isl_pkg::StOk;
    p = int'(c.position);
    case (c.operation)
      isl_pkg::OpInsert: begin
        if (list_len >= isl_pkg::Capacity) begin
          r.status = isl_pkg::StFull;
        end else begin
          if (p > list_len) p = list_len;
          for (int i = list_len; i > p; i--) list_words[i] = list_words[i-1];
          list_words[p] = c.word_in;
          list_len++;
        end
      end
      isl_pkg::OpDelete: begin
        if (p >= list_len) begin
          r.status = isl_pkg::StRange;
        end else begin
          r.word_out = list_words[p];
          for (int i = p; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      isl_pkg::OpRead: begin
        if (p >= list_len) r.status = isl_pkg::StRange;
        else r.word_out = list_words[p];
      end
      isl_pkg::OpWrite: begin
        if (list_len == 0) begin
          r.status = isl_pkg::StRange;
        end else begin
          if (p >= list_len) p = list_len - 1;
          list_words[p] = c.word_in;
        end
      end
      isl_pkg::OpClear: list_len = 0;
      default: ;  // spare codes change nothing
    endcase
    r.entry_count = isl_pkg::CountBits'(list_len);
    if (list_len > peak_len) peak_len = list_len;
    return r;
  endfunction

  task automatic push_cmd(logic [2:0] op, logic [5:0] pos,
                          logic [isl_pkg::WordBits-1:0] word, int gap_pct);
    pending_cmd_t pc;
    pc.cmd.operation = op;
    pc.cmd.position  = pos;
    pc.cmd.word_in   = word;
    pc.gap_pct       = gap_pct;
    pending_q.push_back(pc);
  endtask

  // Random traffic in runs that grow, shrink or churn the list; sim_len tracks
  // occupancy so that most positions land on live entries
  task automatic queue_random_cmds(int n, int gap_pct, inout int sim_len);
    int                           mode;
    int                           mode_left;
    int                           roll;
    logic [2:0]                   op;
    logic [5:0]                   pos;
    logic [isl_pkg::WordBits-1:0] word;
    mode_left = 0;
    mode = 0;
    for (int k = 0; k < n; k++) begin
      if (mode_left == 0) begin
        mode = $urandom_range(2);
        mode_left = $urandom_range(160, 60);
      end
      mode_left--;
      roll = $urandom_range(99);
      if (mode == 0) begin
        // grow
        op = roll < 70 ? isl_pkg::OpInsert : roll < 80 ? isl_pkg::OpDelete :
             roll < 90 ? isl_pkg::OpRead : roll < 98 ? isl_pkg::OpWrite : FirstSpareOp;
      end else if (mode == 1) begin
        // shrink
        op = roll < 15 ? isl_pkg::OpInsert : roll < 75 ? isl_pkg::OpDelete :
             roll < 87 ? isl_pkg::OpRead : roll < 97 ? isl_pkg::OpWrite :
             isl_pkg::OpClear;
      end else begin
        // churn, including clears and spare codes
        op = roll < 30 ? isl_pkg::OpInsert : roll < 55 ? isl_pkg::OpDelete :
             roll < 75 ? isl_pkg::OpRead : roll < 93 ? isl_pkg::OpWrite :
             roll < 96 ? isl_pkg::OpClear :
             3'($urandom_range(LastSpareOp, FirstSpareOp));
      end
      if ($urandom_range(4) == 0 || sim_len == 0) pos = 6'($urandom_range(63));
      else pos = 6'($urandom_range(sim_len - 1));
      roll = $urandom_range(15);
      word = roll == 0 ? '0 : roll == 1 ? '1 : isl_pkg::WordBits'($urandom());
      push_cmd(op, pos, word, gap_pct);
      case (op)
        isl_pkg::OpInsert: if (sim_len < isl_pkg::Capacity) sim_len++;
        isl_pkg::OpDelete: if (int'(pos) < sim_len) sim_len--;
        isl_pkg::OpClear:  sim_len = 0;
        default:  ;
      endcase
    end
  endtask

  // Stimulus build, reset and end of run
  initial begin
    int sim_len;
    int phase_gap [4];
    rst_ni = 1'b0;
    start  = 1'b0;
    cmd_i  = '0;
    phase_gap = '{0, 78, 34, 0};

    // Directed: empty-list errors, front/middle/append inserts, extremes of the
    // word, write past the end, delete and read past the end, spare codes
    push_cmd(isl_pkg::OpRead,   6'd0,  '0, 0);
    push_cmd(isl_pkg::OpDelete, 6'd5,  '0, 0);
    push_cmd(isl_pkg::OpWrite,  6'd0,  32'h1234_5678, 0);
    push_cmd(isl_pkg::OpClear,  6'd0,  '0, 0);
    push_cmd(isl_pkg::OpInsert, 6'd0,  '1, 0);
    push_cmd(isl_pkg::OpInsert, 6'd63, '0, 0);
    push_cmd(isl_pkg::OpInsert, 6'd1,  32'hA5A5_A5A5, 0);
    push_cmd(isl_pkg::OpInsert, 6'd0,  32'h5A5A_5A5A, 0);
    for (int k = 0; k < 4; k++) push_cmd(isl_pkg::OpRead, 6'(k), '0, 0);
    push_cmd(isl_pkg::OpWrite,  6'd63, 32'hDEAD_BEEF, 0);
    push_cmd(isl_pkg::OpWrite,  6'd1,  32'h8000_0001, 0);
    push_cmd(isl_pkg::OpRead,   6'd3,  '0, 0);
    push_cmd(isl_pkg::OpRead,   6'd1,  '0, 0);
    push_cmd(isl_pkg::OpDelete, 6'd1,  '0, 0);
    push_cmd(isl_pkg::OpDelete, 6'd40, '0, 0);
    push_cmd(isl_pkg::OpRead,   6'd63, '0, 0);
    for (int k = FirstSpareOp; k <= LastSpareOp; k++) push_cmd(3'(k), 6'd0, '1, 0);
    push_cmd(isl_pkg::OpDelete, 6'd0,  '0, 0);
    push_cmd(isl_pkg::OpClear,  6'd0,  '0, 0);
    push_cmd(isl_pkg::OpRead,   6'd0,  '0, 0);

    // Random part in phases of sender idling
    sim_len = 0;
    for (int ph = 0; ph < 4; ph++) queue_random_cmds(RandomCmds / 4, phase_gap[ph], sim_len);
    total_cmds = pending_q.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (xfer_count < total_cmds) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    $display("Ran %0d command transfers; peak occupancy %0d of %0d entries,",
             xfer_count, peak_len, isl_pkg::Capacity);
    $display("%0d inserts refused on a full list, %0d index or empty-list errors.",
             full_refusals, range_errors);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timeout at %0t", $time);
    $display("Mismatches found");
    $finish;
  end

  // Driver: a new command goes out once the previous one has transferred
  always @(negedge clk_i) begin
    if (rst_ni && xfer_count == issue_count) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= pending_q[0].gap_pct) begin
        cmd_i <= pending_q[0].cmd;
        start <= 1'b1;
        pending_q.pop_front();
        issue_count++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(string field, logic [isl_pkg::WordBits-1:0] exp_v,
                                 logic [isl_pkg::WordBits-1:0] got_v);
    mismatch_count++;
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, exp_v, got_v);
  endtask

  // Monitor: check results, then predict the command transferring at this edge
  always @(posedge clk_i) begin
    isl_pkg::result_t exp_r;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with none expected, got 0x%0h", $time, result_o);
        end else begin
          exp_r = expected_q.pop_front();
          if (result_o.status !== exp_r.status)
            report_mismatch("status", isl_pkg::WordBits'(exp_r.status),
                            isl_pkg::WordBits'(result_o.status));
          if (result_o.word_out !== exp_r.word_out)
            report_mismatch("word_out", exp_r.word_out, result_o.word_out);
          if (result_o.entry_count !== exp_r.entry_count)
            report_mismatch("entry_count", isl_pkg::WordBits'(exp_r.entry_count),
                            isl_pkg::WordBits'(result_o.entry_count));
        end
      end
      if (start && !busy) begin
        exp_r = apply_list_cmd(cmd_i);
        if (exp_r.status == isl_pkg::StFull) full_refusals++;
        if (exp_r.status == isl_pkg::StRange) range_errors++;
        expected_q.push_back(exp_r);
        xfer_count++;
      end
    end
  end

endmodule
